>>> rtl/core/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg: shared types and constants for the Hermite polynomial evaluator
// Holds the sequencer state type and the fixed datapath widths.
// ----------------------------------------------------------------------------
package hpe_pkg;

    // Word widths fixed by the interface
    localparam int DATA_W = 64;
    localparam int X_W    = 32;
    localparam int ORD_W  = 5;

    // Shared multiplier: 33 x 33 signed, 32-bit halves plus a sign/zero bit
    localparam int HALF_W = 32;
    localparam int MUL_W  = HALF_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Accumulator holds x * He_k exactly (32 x 64 bits)
    localparam int ACC_W  = 96;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_XLO,
        ST_XHI,
        ST_KLO,
        ST_KHI,
        ST_KFIN,
        ST_DLO,
        ST_DHI,
        ST_DFIN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/hermite_polynomial_eval_core.sv
// ----------------------------------------------------------------------------
// hermite_polynomial_eval_core: probabilists' Hermite polynomial evaluator
// Computes He_n(x) or n*He_{n-1}(x) in signed fixed point by the three-term
// recurrence on one shared 33x33 multiplier and one shared wide adder.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; the answer appears on
// result/overflow with done high for exactly one cycle and cannot be held
// off, so capture it on that cycle. With m = order (value) or order-1
// (derivative), an item runs max(m-1, 0) recurrence steps, plus the DLO,
// DHI and DFIN states for a derivative with nonzero order, between CHECK
// and DONE. Each recurrence step makes four passes through the shared
// multiplier for the two 32-bit halves of x*He_k and of k*He_{k-1}, then
// the final subtract and saturate. A new word may be started in the same
// cycle that done is high. Order is clamped to MAX_ORDER; any saturation
// to the 64-bit range sets overflow.
module hermite_polynomial_eval_core
    import hpe_pkg::*;
#(
    parameter int MAX_ORDER = 31,
    parameter int FRAC_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     op,
    input  logic signed [X_W-1:0]    x,
    input  logic [ORD_W-1:0]         order,
    output logic                     done,
    output logic signed [DATA_W-1:0] result,
    output logic                     overflow
);

    localparam int N_W   = $clog2(MAX_ORDER + 1);
    localparam int CMP_W = 8;

    // Sequencer and control
    state_t           state_reg, state_next;
    logic [N_W-1:0]   k_reg, k_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [N_W-1:0]   m_reg, m_next;
    logic             op_reg, op_next;
    logic             ovf_reg, ovf_next;

    // Datapath
    logic signed [X_W-1:0]    x_reg, x_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic signed [DATA_W-1:0] result_reg, result_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0]  add_a, add_b, add_sum;
    logic                     add_sub;
    logic signed [ACC_W-1:0]  prod_ext, prod_sh;
    logic signed [DATA_W-1:0] sat_val;
    logic                     sat_ovf;
    logic signed [DATA_W-1:0] hsel;
    logic [N_W-1:0]           k_inc;
    logic [N_W-1:0]           n_in;
    logic [CMP_W-1:0]         ord_ext;
    logic                     take;

    assign take    = start && !busy;
    assign k_inc   = k_reg + 1'b1;
    assign hsel    = (m_reg == '0) ? prev_reg : cur_reg;
    assign ord_ext = CMP_W'(order);
    assign n_in    = (ord_ext > CMP_W'(MAX_ORDER)) ? N_W'(MAX_ORDER) : N_W'(ord_ext);

    // Shared multiplier, registered
    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_XLO:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = $signed({1'b0, cur_reg[HALF_W-1:0]});
            end
            ST_XHI:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'($signed(cur_reg[DATA_W-1:HALF_W]));
            end
            ST_KLO:
            begin
                mul_a = $signed({1'b0, (MUL_W-1)'(k_reg)});
                mul_b = $signed({1'b0, prev_reg[HALF_W-1:0]});
            end
            ST_KHI:
            begin
                mul_a = $signed({1'b0, (MUL_W-1)'(k_reg)});
                mul_b = MUL_W'($signed(prev_reg[DATA_W-1:HALF_W]));
            end
            ST_DLO:
            begin
                mul_a = $signed({1'b0, (MUL_W-1)'(n_reg)});
                mul_b = $signed({1'b0, hsel[HALF_W-1:0]});
            end
            ST_DHI:
            begin
                mul_a = $signed({1'b0, (MUL_W-1)'(n_reg)});
                mul_b = MUL_W'($signed(hsel[DATA_W-1:HALF_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared adder with operand select
    assign prod_ext = ACC_W'(prod_reg);
    assign prod_sh  = prod_ext <<< HALF_W;

    always_comb
    begin
        add_a   = acc_reg;
        add_b   = prod_sh;
        add_sub = 1'b0;
        case (state_reg)
            ST_KHI:
            begin
                add_a   = acc_reg >>> FRAC_BITS;
                add_b   = prod_ext;
                add_sub = 1'b1;
            end
            ST_KFIN:
            begin
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = prod_sh;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

    // Clamp the adder output to the 64-bit signed range
    always_comb
    begin
        if ((&add_sum[ACC_W-1:DATA_W-1]) || !(|add_sum[ACC_W-1:DATA_W-1]))
        begin
            sat_val = add_sum[DATA_W-1:0];
            sat_ovf = 1'b0;
        end
        else
        begin
            sat_val = add_sum[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
            sat_ovf = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (k_reg < m_reg)
                begin
                    state_next = ST_XLO;
                end
                else if (op_reg && (n_reg != '0))
                begin
                    state_next = ST_DLO;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_XLO:  state_next = ST_XHI;
            ST_XHI:  state_next = ST_KLO;
            ST_KLO:  state_next = ST_KHI;
            ST_KHI:  state_next = ST_KFIN;
            ST_KFIN:
            begin
                if (k_inc < m_reg)
                begin
                    state_next = ST_XLO;
                end
                else if (op_reg)
                begin
                    state_next = ST_DLO;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DLO:  state_next = ST_DHI;
            ST_DHI:  state_next = ST_DFIN;
            ST_DFIN: state_next = ST_DONE;
            ST_DONE:
            begin
                state_next = start ? ST_CHECK : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and control updates
    always_comb
    begin
        k_next      = k_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        op_next     = op_reg;
        ovf_next    = ovf_reg;
        x_next      = x_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        result_next = result_reg;
        acc_next    = acc_reg;
        case (state_reg)
            ST_CHECK:
            begin
                if (!(k_reg < m_reg))
                begin
                    if (op_reg)
                    begin
                        result_next = '0;
                    end
                    else
                    begin
                        result_next = hsel;
                    end
                end
            end
            ST_XHI, ST_DHI:
            begin
                acc_next = prod_ext;
            end
            ST_KLO, ST_KHI:
            begin
                acc_next = add_sum;
            end
            ST_KFIN:
            begin
                prev_next   = cur_reg;
                cur_next    = sat_val;
                result_next = sat_val;
                k_next      = k_inc;
                ovf_next    = ovf_reg | sat_ovf;
            end
            ST_DFIN:
            begin
                result_next = sat_val;
                ovf_next    = ovf_reg | sat_ovf;
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase

        // Load a new word; a derivative at order zero runs no steps
        if (take)
        begin
            op_next   = op;
            n_next    = n_in;
            m_next    = (op && (n_in != '0)) ? (n_in - 1'b1) : n_in;
            k_next    = N_W'(1);
            ovf_next  = 1'b0;
            x_next    = x;
            prev_next = DATA_W'(1) << FRAC_BITS;
            cur_next  = DATA_W'(x);
        end
    end

    // Outputs
    always_comb
    begin
        busy     = !((state_reg == ST_IDLE) || (state_reg == ST_DONE));
        done     = (state_reg == ST_DONE);
        result   = result_reg;
        overflow = ovf_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            m_reg     <= '0;
            op_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            op_reg    <= op_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
    end

    // Checks
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XLO) |-> (k_reg < m_reg))
        else $error("recurrence step started past the target order");

    a_deriv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg && (n_reg == '0)) |-> ((result == '0) && !overflow))
        else $error("derivative at order zero is not zero");

endmodule

>>> sim/tb_hermite_polynomial_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hermite_polynomial_eval_core: self-checking bench for the Hermite core
// Drives a table of directed words and then random words through the
// start/busy handshake with random idle gaps. Answers not typed into the
// table are worked out by a local fixed-point recurrence. Each done strobe
// is compared, field by field, with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module tb_hermite_polynomial_eval_core;
    import hpe_pkg::*;

    localparam int MAX_ORDER  = 31;
    localparam int FRAC_BITS  = 24;
    localparam int WIDE_W     = 128;
    localparam int N_DIR      = 24;
    localparam int N_RAND     = 550;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYC  = 160;

    localparam logic OP_VALUE = 1'b0;
    localparam logic OP_DERIV = 1'b1;

    localparam logic signed [DATA_W-1:0] ONE_FX  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] X_MIN_W = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [DATA_W-1:0] NEG_ONE = 64'shFFFF_FFFF_FF00_0000;
    localparam logic signed [X_W-1:0]    X_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [X_W-1:0]    X_MIN   = 32'sh8000_0000;
    localparam logic signed [X_W-1:0]    X_ONE   = 32'sh0100_0000;
    localparam logic signed [X_W-1:0]    X_NONE  = 32'shFF00_0000;
    localparam logic signed [X_W-1:0]    X_TWO   = 32'sh0200_0000;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = {{65{1'b0}}, {63{1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = {{65{1'b1}}, {63{1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
    } herm_word_t;

    typedef struct packed {
        logic                     opv;
        logic signed [X_W-1:0]    xv;
        logic [ORD_W-1:0]         ord;
        logic                     known;
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     op    = OP_VALUE;
    logic signed [X_W-1:0]    x     = '0;
    logic [ORD_W-1:0]         order = '0;
    logic                     done;
    logic signed [DATA_W-1:0] result;
    logic                     overflow;

    herm_word_t herm_words_q [$];
    int         err_cnt  = 0;
    int         idle_cnt = 0;

    // Directed words: known answers typed in, the rest go through the predictor
    dir_row_t dir_rows [N_DIR] = '{
        '{OP_VALUE, 32'sh0,          5'd0,  1'b1, ONE_FX,          1'b0},
        '{OP_DERIV, X_MIN,           5'd0,  1'b1, 64'sh0,          1'b0},
        '{OP_VALUE, X_MIN,           5'd1,  1'b1, X_MIN_W,         1'b0},
        '{OP_VALUE, X_MAX,           5'd1,  1'b1, 64'sh7FFF_FFFF,  1'b0},
        '{OP_DERIV, X_MAX,           5'd1,  1'b1, ONE_FX,          1'b0},
        '{OP_VALUE, 32'sh0,          5'd2,  1'b1, NEG_ONE,         1'b0},
        '{OP_VALUE, X_MAX,           5'd31, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, X_MIN,           5'd31, 1'b0, 64'sh0,          1'b0},
        '{OP_DERIV, X_MAX,           5'd31, 1'b0, 64'sh0,          1'b0},
        '{OP_DERIV, X_MIN,           5'd31, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, 32'sh0,          5'd30, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, 32'sh0,          5'd31, 1'b0, 64'sh0,          1'b0},
        '{OP_DERIV, 32'sh0,          5'd31, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, -32'sd1,         5'd3,  1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, 32'sd1,          5'd3,  1'b0, 64'sh0,          1'b0},
        '{OP_DERIV, -32'sd1,         5'd2,  1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, X_ONE,           5'd10, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, X_NONE,          5'd10, 1'b0, 64'sh0,          1'b0},
        '{OP_DERIV, X_TWO,           5'd10, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, X_MAX,           5'd2,  1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, X_MIN,           5'd2,  1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, X_MIN,           5'd4,  1'b0, 64'sh0,          1'b0},
        '{OP_DERIV, 32'sh5555_5555,  5'd17, 1'b0, 64'sh0,          1'b0},
        '{OP_VALUE, 32'shAAAA_AAAA,  5'd17, 1'b0, 64'sh0,          1'b0}
    };

    hermite_polynomial_eval_core #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .x        (x),
        .order    (order),
        .done     (done),
        .result   (result),
        .overflow (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Clamp a wide value to the 64-bit word range, flag any clipping
    function automatic logic signed [DATA_W-1:0] clamp_word(
        input logic signed [WIDE_W-1:0] v,
        inout logic                     ovf
    );
        if (v > WIDE_MAX)
        begin
            ovf = 1'b1;
            return WIDE_MAX[DATA_W-1:0];
        end
        if (v < WIDE_MIN)
        begin
            ovf = 1'b1;
            return WIDE_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // He_n(x) by the three-term recurrence, floor on the fraction shift
    function automatic logic signed [DATA_W-1:0] hermite_at(
        input logic signed [X_W-1:0] xp,
        input int unsigned           n,
        inout logic                  ovf
    );
        logic signed [DATA_W-1:0] prev;
        logic signed [DATA_W-1:0] cur;
        logic signed [WIDE_W-1:0] wx;
        logic signed [WIDE_W-1:0] wc;
        logic signed [WIDE_W-1:0] wp;
        logic signed [WIDE_W-1:0] wk;
        logic signed [WIDE_W-1:0] diff;
        prev = ONE_FX;
        cur  = xp;
        if (n == 0)
            return prev;
        wx = xp;
        for (int unsigned k = 1; k < n; k++)
        begin
            wc   = cur;
            wp   = prev;
            wk   = k;
            diff = ((wx * wc) >>> FRAC_BITS) - wk * wp;
            prev = cur;
            cur  = clamp_word(diff, ovf);
        end
        return cur;
    endfunction

    // Expected answer for one word: value or scaled derivative
    function automatic herm_word_t eval_hermite(
        input logic                  opv,
        input logic signed [X_W-1:0] xp,
        input logic [ORD_W-1:0]      ord
    );
        herm_word_t               w;
        int unsigned              n;
        logic                     ovf;
        logic signed [WIDE_W-1:0] scaled;
        logic signed [WIDE_W-1:0] wn;
        ovf = 1'b0;
        n   = ord;
        if (n > MAX_ORDER)
            n = MAX_ORDER;
        if (opv == OP_VALUE)
            w.value = hermite_at(xp, n, ovf);
        else if (n == 0)
            w.value = '0;
        else
        begin
            scaled  = hermite_at(xp, n - 1, ovf);
            wn      = n;
            w.value = clamp_word(scaled * wn, ovf);
        end
        w.ovf = ovf;
        return w;
    endfunction

    // Present one word, hold it until taken, then log its answer
    task automatic send_word(
        input logic                  opv,
        input logic signed [X_W-1:0] xv,
        input logic [ORD_W-1:0]      ord,
        input logic                  known,
        input herm_word_t            typed
    );
        start <= 1'b1;
        op    <= opv;
        x     <= xv;
        order <= ord;
        do
            @(posedge clk);
        while (busy);
        if (known)
            herm_words_q.push_back(typed);
        else
            herm_words_q.push_back(eval_hermite(opv, xv, ord));
    endtask

    // Drop start for a while and put noise on the word fields
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            op    <= 1'($urandom);
            x     <= $urandom;
            order <= ORD_W'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Check each done strobe against the oldest answer; watch for stalls
    always @(posedge clk)
    begin
        herm_word_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cnt = 0;
            else
                idle_cnt = idle_cnt + 1;
            if (done)
            begin
                if (herm_words_q.size() == 0)
                begin
                    $error("done with no word pending");
                    err_cnt++;
                end
                else
                begin
                    want = herm_words_q.pop_front();
                    if (result !== want.value)
                    begin
                        $error("result: expected %0d, actual %0d", want.value, result);
                        err_cnt++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.ovf, overflow);
                        err_cnt++;
                    end
                end
            end
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("tb_hermite_polynomial_eval_core: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic                  opv;
        logic signed [X_W-1:0] xv;
        logic [ORD_W-1:0]      ord;
        int                    gap;

        // Hold reset, then release it before the first word
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            send_word(dir_rows[i].opv, dir_rows[i].xv, dir_rows[i].ord,
                      dir_rows[i].known, '{dir_rows[i].value, dir_rows[i].ovf});
            hold_off($urandom_range(0, 19));
        end

        // Random words: mostly low orders, a quarter over the full range
        for (int i = 0; i < N_RAND; i++)
        begin
            opv = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                ord = ORD_W'($urandom_range(0, 31));
            else
                ord = ORD_W'($urandom_range(0, 10));
            case ($urandom_range(0, 2))
                0: xv = $urandom;
                1: xv = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
                default: xv = ($signed($urandom_range(0, 8)) - 4) * (1 <<< FRAC_BITS)
                              + $signed($urandom_range(0, 4)) - 2;
            endcase
            send_word(opv, xv, ord, 1'b0, '0);

            // Drain fully once mid-run
            if (i == N_RAND / 2)
            begin
                start <= 1'b0;
                while (herm_words_q.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                gap = (i % 100 < 25) ? 0 : $urandom_range(0, 19);
                hold_off(gap);
            end
        end

        // Wait for the last answers, then watch for stray strobes
        start <= 1'b0;
        while (herm_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_cnt == 0)
            $display("tb_hermite_polynomial_eval_core: PASS");
        else
            $display("tb_hermite_polynomial_eval_core: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hpe_pkg.sv
rtl/core/hermite_polynomial_eval_core.sv
sim/tb_hermite_polynomial_eval_core.sv
